FILE: design/mrf_pkg.sv
// Shared types, codes, microcode program and CRC helper for the request framer.
package mrf_pkg;

    localparam int BUFFER_WORDS_DEF = 16;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Modbus function codes
    localparam logic [7:0] FC_READ_COILS     = 8'h01;
    localparam logic [7:0] FC_READ_DISCRETE  = 8'h02;
    localparam logic [7:0] FC_READ_HOLDING   = 8'h03;
    localparam logic [7:0] FC_READ_INPUT     = 8'h04;
    localparam logic [7:0] FC_WRITE_COIL     = 8'h05;
    localparam logic [7:0] FC_WRITE_REG      = 8'h06;
    localparam logic [7:0] FC_WRITE_COILS    = 8'h0F;
    localparam logic [7:0] FC_WRITE_REGS     = 8'h10;
    localparam logic [7:0] FC_MASK_WRITE_REG = 8'h16;
    localparam logic [7:0] FC_READ_WRITE_REGS = 8'h17;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_REQUEST = 2'd1,
        OP_CLEAR   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_QTY   = 2'd2
    } t_status;

    // Byte source selected by one control word
    typedef enum logic [4:0] {
        SRC_SID, SRC_FC,
        SRC_RA_H, SRC_RA_L, SRC_RQ_H, SRC_RQ_L,
        SRC_WA_H, SRC_WA_L, SRC_WQ_H, SRC_WQ_L,
        SRC_W0_H, SRC_W0_L, SRC_W1_H, SRC_W1_L,
        SRC_BCNT, SRC_DATA, SRC_CRC_L, SRC_CRC_H, SRC_STATUS
    } t_src;

    // Condition under which a step emits; otherwise it jumps
    typedef enum logic [2:0] {
        C_ALWAYS, C_READ, C_WADDR, C_WQ, C_W0, C_W1, C_BLOCK
    } t_cond;

    localparam int STEP_W = 5;

    localparam logic [STEP_W-1:0] STEP_SID    = 5'd0;
    localparam logic [STEP_W-1:0] STEP_FC     = 5'd1;
    localparam logic [STEP_W-1:0] STEP_RA_H   = 5'd2;
    localparam logic [STEP_W-1:0] STEP_RA_L   = 5'd3;
    localparam logic [STEP_W-1:0] STEP_RQ_H   = 5'd4;
    localparam logic [STEP_W-1:0] STEP_RQ_L   = 5'd5;
    localparam logic [STEP_W-1:0] STEP_WA_H   = 5'd6;
    localparam logic [STEP_W-1:0] STEP_WA_L   = 5'd7;
    localparam logic [STEP_W-1:0] STEP_WQ_H   = 5'd8;
    localparam logic [STEP_W-1:0] STEP_WQ_L   = 5'd9;
    localparam logic [STEP_W-1:0] STEP_W0_H   = 5'd10;
    localparam logic [STEP_W-1:0] STEP_W0_L   = 5'd11;
    localparam logic [STEP_W-1:0] STEP_W1_H   = 5'd12;
    localparam logic [STEP_W-1:0] STEP_W1_L   = 5'd13;
    localparam logic [STEP_W-1:0] STEP_BCNT   = 5'd14;
    localparam logic [STEP_W-1:0] STEP_DATA   = 5'd15;
    localparam logic [STEP_W-1:0] STEP_CRC_L  = 5'd16;
    localparam logic [STEP_W-1:0] STEP_CRC_H  = 5'd17;
    localparam logic [STEP_W-1:0] STEP_STATUS = 5'd18;

    typedef struct packed {
        t_src              src;
        t_cond             cond;
        logic [STEP_W-1:0] jmp;   // target when the condition fails
        logic              loop;  // repeat while data bytes remain
        logic              last;  // final word of the item
    } t_uword;

    // Function-code class flags, decoded once per request
    typedef struct packed {
        logic rd;
        logic wa;
        logic wq;
        logic w0;
        logic w1;
        logic blk;
        logic coil;
    } t_fc_class;

    typedef struct packed {
        logic              go;
        logic [STEP_W-1:0] step;
    } t_start;

    typedef struct packed {
        logic emit;
        t_src src;
        logic last;
        logic adv;
    } t_seq_ctl;

    // Control store
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        case (step)
            STEP_SID:    w = '{SRC_SID,    C_ALWAYS, STEP_FC,     1'b0, 1'b0};
            STEP_FC:     w = '{SRC_FC,     C_ALWAYS, STEP_RA_H,   1'b0, 1'b0};
            STEP_RA_H:   w = '{SRC_RA_H,   C_READ,   STEP_WA_H,   1'b0, 1'b0};
            STEP_RA_L:   w = '{SRC_RA_L,   C_READ,   STEP_WA_H,   1'b0, 1'b0};
            STEP_RQ_H:   w = '{SRC_RQ_H,   C_READ,   STEP_WA_H,   1'b0, 1'b0};
            STEP_RQ_L:   w = '{SRC_RQ_L,   C_READ,   STEP_WA_H,   1'b0, 1'b0};
            STEP_WA_H:   w = '{SRC_WA_H,   C_WADDR,  STEP_WQ_H,   1'b0, 1'b0};
            STEP_WA_L:   w = '{SRC_WA_L,   C_WADDR,  STEP_WQ_H,   1'b0, 1'b0};
            STEP_WQ_H:   w = '{SRC_WQ_H,   C_WQ,     STEP_W0_H,   1'b0, 1'b0};
            STEP_WQ_L:   w = '{SRC_WQ_L,   C_WQ,     STEP_W0_H,   1'b0, 1'b0};
            STEP_W0_H:   w = '{SRC_W0_H,   C_W0,     STEP_W1_H,   1'b0, 1'b0};
            STEP_W0_L:   w = '{SRC_W0_L,   C_W0,     STEP_W1_H,   1'b0, 1'b0};
            STEP_W1_H:   w = '{SRC_W1_H,   C_W1,     STEP_BCNT,   1'b0, 1'b0};
            STEP_W1_L:   w = '{SRC_W1_L,   C_W1,     STEP_BCNT,   1'b0, 1'b0};
            STEP_BCNT:   w = '{SRC_BCNT,   C_BLOCK,  STEP_CRC_L,  1'b0, 1'b0};
            STEP_DATA:   w = '{SRC_DATA,   C_BLOCK,  STEP_CRC_L,  1'b1, 1'b0};
            STEP_CRC_L:  w = '{SRC_CRC_L,  C_ALWAYS, STEP_CRC_H,  1'b0, 1'b0};
            STEP_CRC_H:  w = '{SRC_CRC_H,  C_ALWAYS, STEP_SID,    1'b0, 1'b1};
            STEP_STATUS: w = '{SRC_STATUS, C_ALWAYS, STEP_SID,    1'b0, 1'b1};
            default:     w = '{SRC_STATUS, C_ALWAYS, STEP_SID,    1'b0, 1'b1};
        endcase
        return w;
    endfunction

    // One byte of CRC-16, reflected, LSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: design/mrf_intf.sv
// Request and result channel interfaces for the request framer.
interface mrf_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  word_index;
    logic [15:0] word_value;
    logic [7:0]  slave_id;
    logic [7:0]  function_code;
    logic [15:0] read_address;
    logic [15:0] read_quantity;
    logic [15:0] write_address;
    logic [15:0] write_quantity;

    modport source (
        output valid, opcode, word_index, word_value, slave_id, function_code,
               read_address, read_quantity, write_address, write_quantity,
        input  ready
    );
    modport sink (
        input  valid, opcode, word_index, word_value, slave_id, function_code,
               read_address, read_quantity, write_address, write_quantity,
        output ready
    );
endinterface

interface mrf_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;
    logic [1:0] status;

    modport source (output valid, frame_byte, last_byte, status, input ready);
    modport sink   (input valid, frame_byte, last_byte, status, output ready);
endinterface

FILE: design/mrf_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module mrf_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mrf_pkg::t_start    i_start,
    input  mrf_pkg::t_fc_class i_cls,
    input  logic               i_left_zero,
    input  logic               i_out_free,
    output mrf_pkg::t_seq_ctl  o_ctl,
    output logic               o_busy
);
    import mrf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_seq_state;

    t_seq_state        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    t_uword            uw;
    logic              cond_ok;
    logic              go;

    assign uw = ucode(r_step);

    always_comb begin
        case (uw.cond)
            C_ALWAYS: cond_ok = 1'b1;
            C_READ:   cond_ok = i_cls.rd;
            C_WADDR:  cond_ok = i_cls.wa;
            C_WQ:     cond_ok = i_cls.wq;
            C_W0:     cond_ok = i_cls.w0;
            C_W1:     cond_ok = i_cls.w1;
            C_BLOCK:  cond_ok = i_cls.blk;
            default:  cond_ok = 1'b0;
        endcase
    end

    // a looping step falls through once its byte count runs out
    assign go = cond_ok && !(uw.loop && i_left_zero);

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_ctl.emit = 1'b0;
        o_ctl.src  = uw.src;
        o_ctl.last = uw.last;
        o_ctl.adv  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start.go) begin
                    n_state = S_RUN;
                    n_step  = i_start.step;
                end
            end
            S_RUN: begin
                if (!go) begin
                    n_step = uw.jmp;
                end else if (i_out_free) begin
                    o_ctl.emit = 1'b1;
                    o_ctl.adv  = uw.loop;
                    if (uw.last) begin
                        n_state = S_IDLE;
                    end else if (!uw.loop) begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= STEP_SID;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: design/mrf_dp.sv
// Datapath: request fields, transmit buffer, byte select, CRC and result register.
module mrf_dp #(
    parameter int BUFFER_WORDS = mrf_pkg::BUFFER_WORDS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_busy,
    input  mrf_pkg::t_seq_ctl  i_ctl,
    mrf_req_if.sink            i_req,
    mrf_res_if.source          o_rsp,
    output mrf_pkg::t_start    o_start,
    output mrf_pkg::t_fc_class o_cls,
    output logic               o_left_zero,
    output logic               o_out_free
);
    import mrf_pkg::*;

    localparam int IDX_W  = $clog2(BUFFER_WORDS);
    localparam int BIDX_W = IDX_W + 1;
    localparam int CNT_W  = $clog2(2 * BUFFER_WORDS + 1);
    localparam logic [15:0] WQ_REG_MAX  = 16'(BUFFER_WORDS);
    localparam logic [15:0] WQ_COIL_MAX = 16'(16 * BUFFER_WORDS);

    logic [15:0] r_buf [BUFFER_WORDS];

    logic [7:0]   r_sid, r_fc;
    logic [15:0]  r_ra, r_rq, r_wa, r_wq;
    logic [15:0]  r_crc;
    t_fc_class    r_cls, cls;
    t_status      r_status, status_in;
    logic [CNT_W-1:0]  r_left, count_in;
    logic [BIDX_W-1:0] r_bidx;

    logic         r_ovalid;
    logic [7:0]   r_obyte;
    logic         r_olast;
    t_status      r_ostat;

    logic         accept;
    logic         in_range;
    logic         too_big;
    logic         start_go;
    logic [STEP_W-1:0] start_step;
    logic [16:0]  coil_sum;
    logic [15:0]  data_word;
    logic [7:0]   data_byte;
    logic [7:0]   byte_sel;
    logic         crc_upd;

    assign i_req.ready = i_rst_n && !i_busy;
    assign accept      = i_req.valid && i_req.ready;
    assign in_range    = (i_req.word_index < 8'(BUFFER_WORDS));

    always_comb begin
        cls.rd   = i_req.function_code inside {FC_READ_COILS, FC_READ_DISCRETE,
                   FC_READ_HOLDING, FC_READ_INPUT, FC_READ_WRITE_REGS};
        cls.wa   = i_req.function_code inside {FC_WRITE_COIL, FC_WRITE_REG,
                   FC_WRITE_COILS, FC_WRITE_REGS, FC_MASK_WRITE_REG, FC_READ_WRITE_REGS};
        cls.wq   = i_req.function_code inside {FC_WRITE_COIL, FC_WRITE_COILS,
                   FC_WRITE_REGS, FC_READ_WRITE_REGS};
        cls.w0   = i_req.function_code inside {FC_WRITE_REG, FC_MASK_WRITE_REG};
        cls.w1   = (i_req.function_code == FC_MASK_WRITE_REG);
        cls.blk  = i_req.function_code inside {FC_WRITE_COILS, FC_WRITE_REGS,
                   FC_READ_WRITE_REGS};
        cls.coil = (i_req.function_code == FC_WRITE_COILS);
    end

    always_comb begin
        too_big = ((i_req.function_code == FC_WRITE_REGS ||
                    i_req.function_code == FC_READ_WRITE_REGS) &&
                   i_req.write_quantity > WQ_REG_MAX) ||
                  (i_req.function_code == FC_WRITE_COILS &&
                   i_req.write_quantity > WQ_COIL_MAX);
        coil_sum = {1'b0, i_req.write_quantity} + 17'd7;
        // coil bytes ceil(q/8), register bytes 2q; both bounded once not too big
        count_in = cls.coil ? CNT_W'(coil_sum[16:3]) : CNT_W'({i_req.write_quantity, 1'b0});
    end

    always_comb begin
        start_go   = 1'b1;
        start_step = STEP_STATUS;
        status_in  = ST_OK;
        case (i_req.opcode)
            OP_LOAD: begin
                status_in = in_range ? ST_OK : ST_RANGE;
            end
            OP_CLEAR: begin
                status_in = ST_OK;
            end
            OP_REQUEST: begin
                if (too_big) begin
                    status_in = ST_QTY;
                end else begin
                    start_step = STEP_SID;
                end
            end
            default: begin
                start_go = 1'b0;
            end
        endcase
    end

    assign o_start.go   = accept && start_go;
    assign o_start.step = start_step;

    // transmit buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < BUFFER_WORDS; k++) begin
                r_buf[k] <= '0;
            end
        end else if (accept) begin
            if (i_req.opcode == OP_CLEAR) begin
                for (int k = 0; k < BUFFER_WORDS; k++) begin
                    r_buf[k] <= '0;
                end
            end else if (i_req.opcode == OP_LOAD && in_range) begin
                r_buf[i_req.word_index[IDX_W-1:0]] <= i_req.word_value;
            end
        end
    end

    // request fields, data cursor and running CRC
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sid    <= i_req.slave_id;
            r_fc     <= i_req.function_code;
            r_ra     <= i_req.read_address;
            r_rq     <= i_req.read_quantity;
            r_wa     <= i_req.write_address;
            r_wq     <= i_req.write_quantity;
            r_cls    <= cls;
            r_status <= status_in;
            r_left   <= count_in;
            r_bidx   <= '0;
            r_crc    <= CRC_INIT;
        end else begin
            if (i_ctl.adv) begin
                r_left <= r_left - 1'b1;
                r_bidx <= r_bidx + 1'b1;
            end
            if (crc_upd) begin
                r_crc <= crc16_byte(r_crc, byte_sel);
            end
        end
    end

    // coils go low byte first, registers high byte first
    assign data_word = r_buf[r_bidx[BIDX_W-1:1]];
    assign data_byte = (r_bidx[0] ^ !r_cls.coil) ? data_word[15:8] : data_word[7:0];

    always_comb begin
        case (i_ctl.src)
            SRC_SID:    byte_sel = r_sid;
            SRC_FC:     byte_sel = r_fc;
            SRC_RA_H:   byte_sel = r_ra[15:8];
            SRC_RA_L:   byte_sel = r_ra[7:0];
            SRC_RQ_H:   byte_sel = r_rq[15:8];
            SRC_RQ_L:   byte_sel = r_rq[7:0];
            SRC_WA_H:   byte_sel = r_wa[15:8];
            SRC_WA_L:   byte_sel = r_wa[7:0];
            SRC_WQ_H:   byte_sel = r_wq[15:8];
            SRC_WQ_L:   byte_sel = r_wq[7:0];
            SRC_W0_H:   byte_sel = r_buf[0][15:8];
            SRC_W0_L:   byte_sel = r_buf[0][7:0];
            SRC_W1_H:   byte_sel = r_buf[1][15:8];
            SRC_W1_L:   byte_sel = r_buf[1][7:0];
            SRC_BCNT:   byte_sel = 8'(r_left);
            SRC_DATA:   byte_sel = data_byte;
            SRC_CRC_L:  byte_sel = r_crc[7:0];
            SRC_CRC_H:  byte_sel = r_crc[15:8];
            default:    byte_sel = 8'h00;
        endcase
    end

    assign crc_upd = i_ctl.emit && !(i_ctl.src == SRC_CRC_L || i_ctl.src == SRC_CRC_H ||
                                     i_ctl.src == SRC_STATUS);

    // result register
    assign o_out_free = !r_ovalid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_ctl.emit) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_obyte <= byte_sel;
            r_olast <= i_ctl.last;
            r_ostat <= (i_ctl.src == SRC_STATUS) ? r_status : ST_OK;
        end
    end

    assign o_rsp.valid      = r_ovalid;
    assign o_rsp.frame_byte = r_obyte;
    assign o_rsp.last_byte  = r_olast;
    assign o_rsp.status     = r_ostat;

    assign o_cls       = r_cls;
    assign o_left_zero = (r_left == '0);

endmodule

FILE: design/modbus_rtu_request_framer.sv
// Flow: an accepted item starts the sequencer, whose emitted words are registered in the result register;
// a frame of N bytes, 45 at most, streams one byte per cycle while the result side takes
// each word, pausing at each jump past an absent field group or out of the data loop (at most 6).
// One item at a time; the next item is accepted the cycle after the sequencer issues the last
// word of the previous one; load, clear and reject give one status word, held while the result
// side holds the previous one. Reset: synchronous, active low; buffer zeroed, sequencer idle,
// result register empty, input not ready while reset is held.
module modbus_rtu_request_framer #(
    parameter int BUFFER_WORDS = mrf_pkg::BUFFER_WORDS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mrf_req_if.sink   i_req,
    mrf_res_if.source o_rsp
);
    import mrf_pkg::*;

    // Control flows from the sequencer to the datapath as one control word per step.
    // The datapath reports the decoded function-code class, whether data bytes remain
    // and whether the result register can take a word; the sequencer uses these to
    // pick between emitting a byte and jumping past a field group.
    t_seq_ctl  ctl;
    t_start    start;
    t_fc_class cls;
    logic      left_zero;
    logic      out_free;
    logic      busy;

    // Sequencer: steps through the control store, skips absent fields, loops on data.
    mrf_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cls       (cls),
        .i_left_zero (left_zero),
        .i_out_free  (out_free),
        .o_ctl       (ctl),
        .o_busy      (busy)
    );

    // Datapath: holds the request, the transmit buffer, the CRC and the result word.
    mrf_dp #(
        .BUFFER_WORDS (BUFFER_WORDS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_busy      (busy),
        .i_ctl       (ctl),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_start     (start),
        .o_cls       (cls),
        .o_left_zero (left_zero),
        .o_out_free  (out_free)
    );

    // A non-OK status is always a single-word result.
    a_status_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.status != ST_OK |-> o_rsp.last_byte && o_rsp.frame_byte == 8'h00)
        else $error("error status word is not a lone final word");

    // An accepted request holds off further input for at least the next cycle.
    a_req_blocks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready && i_req.opcode == OP_REQUEST |=> !i_req.ready)
        else $error("input accepted while a request is in progress");

    // An unused opcode produces nothing and leaves the block ready.
    a_unused_op : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready && i_req.opcode != OP_LOAD &&
        i_req.opcode != OP_REQUEST && i_req.opcode != OP_CLEAR |=> i_req.ready)
        else $error("unused opcode started the sequencer");

    // Sequencer only emits into a free result register.
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.emit |-> out_free)
        else $error("result word overwritten before it was taken");

endmodule

FILE: test/mrf_frame_checker.sv
// Frame checker: mirrors the transmit buffer, predicts every result word and compares it.
module mrf_frame_checker #(
    parameter int BUFFER_WORDS = mrf_pkg::BUFFER_WORDS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mrf_req_if   i_req,
    mrf_res_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);
    import mrf_pkg::*;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
        logic [1:0] status;
    } result_word_t;

    logic [15:0]  tx_copy [BUFFER_WORDS];
    logic [7:0]   frame_bytes [$];
    result_word_t expected_words [$];
    int           fail_total;
    int           checked_total;

    function automatic void push_be16(input logic [15:0] v);
        frame_bytes.push_back(v[15:8]);
        frame_bytes.push_back(v[7:0]);
    endfunction

    function automatic void expect_status(input t_status st);
        expected_words.push_back('{8'h00, 1'b1, st});
    endfunction

    // Queue one word per frame byte with CRC, or a status word for an oversize quantity.
    function automatic void predict_request(input logic [7:0] sid, fc,
                                            input logic [15:0] ra, rq, wa, wq);
        logic [15:0] crc;
        logic [15:0] w;
        int unsigned n_data;
        frame_bytes.delete();
        if ((fc == FC_WRITE_REGS || fc == FC_READ_WRITE_REGS) && wq > BUFFER_WORDS) begin
            expect_status(ST_QTY);
            return;
        end
        if (fc == FC_WRITE_COILS && wq > 16 * BUFFER_WORDS) begin
            expect_status(ST_QTY);
            return;
        end
        frame_bytes.push_back(sid);
        frame_bytes.push_back(fc);
        if (fc inside {FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT,
                       FC_READ_WRITE_REGS}) begin
            push_be16(ra);
            push_be16(rq);
        end
        if (fc inside {FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS,
                       FC_MASK_WRITE_REG, FC_READ_WRITE_REGS})
            push_be16(wa);
        case (fc)
            FC_WRITE_COIL: push_be16(wq);
            FC_WRITE_REG:  push_be16(tx_copy[0]);
            FC_WRITE_COILS: begin
                push_be16(wq);
                n_data = (32'(wq) + 7) >> 3;
                frame_bytes.push_back(8'(n_data));
                // coil data goes out low byte first within each word
                for (int unsigned i = 0; i < n_data; i++) begin
                    w = tx_copy[(i >> 1) % BUFFER_WORDS];
                    frame_bytes.push_back(i[0] ? w[15:8] : w[7:0]);
                end
            end
            FC_WRITE_REGS, FC_READ_WRITE_REGS: begin
                push_be16(wq);
                frame_bytes.push_back(8'(2 * 32'(wq)));
                for (int unsigned i = 0; i < 32'(wq); i++)
                    push_be16(tx_copy[i % BUFFER_WORDS]);
            end
            FC_MASK_WRITE_REG: begin
                push_be16(tx_copy[0]);
                push_be16(tx_copy[1]);
            end
            default: ;
        endcase
        crc = CRC_INIT;
        foreach (frame_bytes[k]) begin
            crc = crc ^ {8'h00, frame_bytes[k]};
            repeat (8) crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
        end
        frame_bytes.push_back(crc[7:0]);
        frame_bytes.push_back(crc[15:8]);
        foreach (frame_bytes[k])
            expected_words.push_back('{frame_bytes[k], k == frame_bytes.size() - 1, ST_OK});
    endfunction

    always @(posedge i_clk) begin
        result_word_t got;
        result_word_t want;
        if (!i_rst_n) begin
            foreach (tx_copy[k]) tx_copy[k] = '0;
            expected_words.delete();
            fail_total    = 0;
            checked_total = 0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                case (i_req.opcode)
                    OP_LOAD: begin
                        if (i_req.word_index < BUFFER_WORDS) begin
                            tx_copy[i_req.word_index] = i_req.word_value;
                            expect_status(ST_OK);
                        end else begin
                            expect_status(ST_RANGE);
                        end
                    end
                    OP_CLEAR: begin
                        foreach (tx_copy[k]) tx_copy[k] = '0;
                        expect_status(ST_OK);
                    end
                    OP_REQUEST: predict_request(i_req.slave_id, i_req.function_code,
                                                i_req.read_address, i_req.read_quantity,
                                                i_req.write_address, i_req.write_quantity);
                    default: ;  // unused opcode: dropped, nothing comes back
                endcase
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got = '{i_rsp.frame_byte, i_rsp.last_byte, i_rsp.status};
                checked_total++;
                if (expected_words.size() == 0) begin
                    fail_total++;
                    $display({"%0t: unexpected result word: expected none, ",
                              "got byte=%02h last=%0b status=%0d"},
                             $time, got.frame_byte, got.last_byte, got.status);
                end else begin
                    want = expected_words.pop_front();
                    if (got.frame_byte !== want.frame_byte || got.last_byte !== want.last_byte
                        || got.status !== want.status) begin
                        fail_total++;
                        $display({"%0t: result word mismatch: expected byte=%02h last=%0b ",
                                  "status=%0d, got byte=%02h last=%0b status=%0d"},
                                 $time, want.frame_byte, want.last_byte, want.status,
                                 got.frame_byte, got.last_byte, got.status);
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_words.size();
        o_checked    <= checked_total;
    end

endmodule

FILE: test/modbus_rtu_request_framer_tb.sv
// Testbench top for the request framer: drives request words, paces results, gives the verdict.
module modbus_rtu_request_framer_tb;
    import mrf_pkg::*;

    localparam int BW = BUFFER_WORDS_DEF;

    // Opcode the block must drop without any result
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int STALL_LIMIT     = 4000;  // cycles with no word moving on either side
    localparam int HOLD_OFF_CYCLES = 400;   // receiver back-pressure stretch
    localparam int TAIL_CYCLES     = 64;    // settle time after the last result
    localparam int RANDOM_WORDS    = 290;

    localparam logic [7:0] FC_KNOWN [10] = '{
        FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT, FC_WRITE_COIL,
        FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS, FC_MASK_WRITE_REG, FC_READ_WRITE_REGS
    };

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  idx;
        logic [15:0] val;
        logic [7:0]  sid;
        logic [7:0]  fc;
        logic [15:0] ra;
        logic [15:0] rq;
        logic [15:0] wa;
        logic [15:0] wq;
    } req_word_t;

    logic clk;
    logic rst_n;
    logic hold_off;
    logic idle_on;

    int n_load    = 0;
    int n_request = 0;
    int n_clear   = 0;
    int n_ignored = 0;
    int quiet_cycles = 0;

    int chk_fails;
    int chk_pending;
    int chk_checked;

    mrf_req_if req_ch ();
    mrf_res_if rsp_ch ();

    modbus_rtu_request_framer #(
        .BUFFER_WORDS(BW)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    mrf_frame_checker #(
        .BUFFER_WORDS(BW)
    ) frame_chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_ch),
        .i_rsp       (rsp_ch),
        .o_fail_count(chk_fails),
        .o_pending   (chk_pending),
        .o_checked   (chk_checked)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Result side: hold ready low during the back-pressure stretch, otherwise
    // drop it about a tenth of the time while idling is on.
    always @(negedge clk) begin
        if (hold_off)
            rsp_ch.ready <= 1'b0;
        else if (idle_on)
            rsp_ch.ready <= ($urandom_range(0, 99) >= 10);
        else
            rsp_ch.ready <= 1'b1;
    end

    // Watchdog: count cycles in which no word moves on either channel.
    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no word accepted for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Draw a fully random word, then bias it toward well-formed commands so
    // most requests produce complete frames rather than rejects.
    function automatic req_word_t random_item();
        req_word_t w;
        int unsigned pick;
        w.op  = 2'($urandom);
        w.idx = 8'($urandom);
        w.val = 16'($urandom);
        w.sid = 8'($urandom);
        w.fc  = 8'($urandom);
        w.ra  = 16'($urandom);
        w.rq  = 16'($urandom);
        w.wa  = 16'($urandom);
        w.wq  = 16'($urandom);
        pick  = $urandom_range(0, 99);
        if (pick < 28) begin
            w.op = OP_LOAD;
            if ($urandom_range(0, 9) < 8)
                w.idx = 8'($urandom_range(0, BW - 1));
        end else if (pick < 33) begin
            w.op = OP_CLEAR;
        end else if (pick < 36) begin
            w.op = OP_UNUSED;
        end else begin
            w.op = OP_REQUEST;
            if ($urandom_range(0, 9) < 8)
                w.fc = FC_KNOWN[$urandom_range(0, 9)];
            case (w.fc)
                FC_WRITE_COILS:
                    if ($urandom_range(0, 9) < 8) w.wq = 16'($urandom_range(0, 16 * BW));
                FC_WRITE_REGS, FC_READ_WRITE_REGS:
                    if ($urandom_range(0, 9) < 8) w.wq = 16'($urandom_range(0, BW));
                FC_WRITE_COIL:
                    if ($urandom_range(0, 1) == 1) w.wq = $urandom_range(0, 1) ? 16'hFF00 : 16'h0000;
                default: ;
            endcase
        end
        return w;
    endfunction

    // Offer one word and hold it until the block takes it. Idle cycles, if
    // any, come first, so valid changes at most once per falling edge.
    task automatic push_item(input req_word_t w);
        @(negedge clk);
        while (idle_on && $urandom_range(0, 99) < 10) begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.opcode         <= w.op;
        req_ch.word_index     <= w.idx;
        req_ch.word_value     <= w.val;
        req_ch.slave_id       <= w.sid;
        req_ch.function_code  <= w.fc;
        req_ch.read_address   <= w.ra;
        req_ch.read_quantity  <= w.rq;
        req_ch.write_address  <= w.wa;
        req_ch.write_quantity <= w.wq;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        case (w.op)
            OP_LOAD:    n_load++;
            OP_REQUEST: n_request++;
            OP_CLEAR:   n_clear++;
            default:    n_ignored++;
        endcase
    endtask

    task automatic load_word(input logic [7:0] idx, input logic [15:0] val);
        req_word_t w;
        w     = random_item();
        w.op  = OP_LOAD;
        w.idx = idx;
        w.val = val;
        push_item(w);
    endtask

    task automatic send_request(input logic [7:0] sid, fc,
                                input logic [15:0] ra, rq, wa, wq);
        req_word_t w;
        w    = random_item();
        w.op = OP_REQUEST;
        w.sid = sid;
        w.fc  = fc;
        w.ra  = ra;
        w.rq  = rq;
        w.wa  = wa;
        w.wq  = wq;
        push_item(w);
    endtask

    task automatic send_bare(input logic [1:0] op);
        req_word_t w;
        w    = random_item();
        w.op = op;
        push_item(w);
    endtask

    // Send random words; dropped opcodes do not count toward the total.
    task automatic send_random(input int count);
        req_word_t w;
        int sent;
        sent = 0;
        while (sent < count) begin
            w = random_item();
            push_item(w);
            if (w.op != OP_UNUSED) sent++;
        end
    endtask

    // Lower valid and wait until every predicted result word has come back.
    task automatic pause_until_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0) @(posedge clk);
    endtask

    initial begin
        rst_n                 = 1'b0;
        hold_off              = 1'b0;
        idle_on               = 1'b1;
        req_ch.valid          = 1'b0;
        req_ch.opcode         = '0;
        req_ch.word_index     = '0;
        req_ch.word_value     = '0;
        req_ch.slave_id       = '0;
        req_ch.function_code  = '0;
        req_ch.read_address   = '0;
        req_ch.read_quantity  = '0;
        req_ch.write_address  = '0;
        req_ch.write_quantity = '0;
        rsp_ch.ready          = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Single register write right after reset: the buffer must read as zero.
        send_request(8'h00, FC_WRITE_REG, 16'($urandom), 16'($urandom), 16'h0000, 16'($urandom));

        // Loads: both ends of the index range, then past it.
        load_word(8'd0, 16'hFFFF);
        load_word(8'd1, 16'h8001);
        load_word(8'(BW - 1), 16'hA55A);
        load_word(8'(BW), 16'h1234);
        load_word(8'hFF, 16'h0000);

        // Read function codes and single writes, with address and quantity extremes.
        send_request(8'hFF, FC_READ_COILS, 16'h0000, 16'hFFFF, 16'($urandom), 16'($urandom));
        send_request(8'($urandom), FC_READ_DISCRETE, 16'hFFFF, 16'h0000, 16'($urandom),
                     16'($urandom));
        send_request(8'($urandom), FC_READ_HOLDING, 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom));
        send_request(8'($urandom), FC_READ_INPUT, 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom));
        send_request(8'($urandom), FC_WRITE_COIL, 16'($urandom), 16'($urandom), 16'hFFFF,
                     16'hFF00);
        send_request(8'($urandom), FC_WRITE_COIL, 16'($urandom), 16'($urandom), 16'h0000,
                     16'h0000);
        send_request(8'($urandom), FC_WRITE_REG, 16'($urandom), 16'($urandom), 16'hFFFF,
                     16'($urandom));

        // Coil writes: empty, exactly the buffer, one past the buffer.
        send_request(8'($urandom), FC_WRITE_COILS, 16'($urandom), 16'($urandom),
                     16'($urandom), 16'd0);
        send_request(8'($urandom), FC_WRITE_COILS, 16'($urandom), 16'($urandom),
                     16'($urandom), 16'(16 * BW));
        send_request(8'($urandom), FC_WRITE_COILS, 16'($urandom), 16'($urandom),
                     16'($urandom), 16'(16 * BW + 1));

        // Register writes: full buffer, one too many, none.
        send_request(8'($urandom), FC_WRITE_REGS, 16'($urandom), 16'($urandom),
                     16'($urandom), 16'(BW));
        send_request(8'($urandom), FC_WRITE_REGS, 16'($urandom), 16'($urandom),
                     16'($urandom), 16'(BW + 1));
        send_request(8'($urandom), FC_WRITE_REGS, 16'($urandom), 16'($urandom),
                     16'($urandom), 16'd0);

        send_request(8'($urandom), FC_MASK_WRITE_REG, 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom));
        send_request(8'($urandom), FC_READ_WRITE_REGS, 16'hFFFF, 16'hFFFF, 16'h0000,
                     16'(BW));
        send_request(8'($urandom), FC_READ_WRITE_REGS, 16'($urandom), 16'($urandom),
                     16'($urandom), 16'hFFFF);

        // Unknown codes at both ends: header and CRC only.
        send_request(8'($urandom), 8'h00, 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom));
        send_request(8'($urandom), 8'hFF, 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom));

        // Dropped opcode, then clear and prove the data block reads back zero.
        send_bare(OP_UNUSED);
        send_bare(OP_CLEAR);
        send_request(8'($urandom), FC_WRITE_REGS, 16'($urandom), 16'($urandom),
                     16'($urandom), 16'd3);

        send_random(120);

        // Back-pressure: hold the result side off while words keep coming, so
        // the block fills and stalls its request side.
        fork
            begin
                hold_off = 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
            send_random(30);
        join

        pause_until_drained();

        // Run a stretch at full rate on both sides.
        idle_on = 1'b0;
        send_random(100);
        idle_on = 1'b1;
        send_random(RANDOM_WORDS - 250);

        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d loads, %0d requests, %0d clears, %0d dropped opcodes",
                 n_load, n_request, n_clear, n_ignored);
        $display("compared %0d result words, %0d failures, %0d still outstanding",
                 chk_checked, chk_fails, chk_pending);
        if (chk_fails == 0 && chk_pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: files.f
design/mrf_pkg.sv
design/mrf_intf.sv
design/mrf_seq.sv
design/mrf_dp.sv
design/modbus_rtu_request_framer.sv
test/mrf_frame_checker.sv
test/modbus_rtu_request_framer_tb.sv
